// File: hdl/clniq_pkg.sv
// Package for the 4-bit character-LCD controller with byte queue.
// Holds the controller states, result and input codes, and power-up constants.
// No dependencies.
`timescale 1ns / 1ps

package clniq_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;

  localparam int ENTRY_W = 9;
  localparam int DATA_W  = 8;
  localparam int NIB_W   = 4;
  localparam int CMD_W   = 2;
  localparam int KIND_W  = 2;
  localparam int START_W = 5;
  localparam int PACE_W  = 8;

  // input commands
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_COMMAND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHAR = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_STROBE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RS = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUEUED = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DROPPED = 2'd3;

  // configuration register indexes
  localparam logic REG_INIT_FUNCTION = 1'b0;
  localparam logic REG_DISPLAY_CONTROL = 1'b1;

  localparam logic [DATA_W-1:0] INIT_FUNCTION_RST = 8'd40;
  localparam logic [DATA_W-1:0] DISPLAY_CONTROL_RST = 8'd12;

  // power-up sequence steps (counted down)
  localparam logic [START_W-1:0] STARTUP_TICKS = 5'd30;
  localparam logic [START_W-1:0] STEP_WAKE = 5'd10;
  localparam logic [START_W-1:0] STEP_PULSE_A = 5'd5;
  localparam logic [START_W-1:0] STEP_PULSE_B = 5'd4;
  localparam logic [START_W-1:0] STEP_FUNC_HI = 5'd3;
  localparam logic [START_W-1:0] STEP_FUNC = 5'd2;
  localparam logic [START_W-1:0] STEP_DISPLAY = 5'd1;

  localparam logic [NIB_W-1:0] EARLY_NIBBLE = 4'h3;

  localparam logic [PACE_W-1:0] PACE_TOP = 8'd255;
  localparam logic [PACE_W-1:0] SLOW_RELOAD = 8'd210;
  localparam logic [DATA_W-1:0] SLOW_LIMIT = 8'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_READ,
    ST_SECOND
  } state_t;

endpackage

// File: hdl/char_lcd_nibble_interface_queue.sv
// Top level of the 4-bit character-LCD controller with a ring queue of bytes.
// Uses clniq_pkg for states, codes and constants; the queue is a local memory.
//
// channel  direction  ports                                handshake
// in       input      in_cmd, in_data_byte                 in_valid / in_ready
// out      output     out_kind, out_rs_level, out_nibble,  out_valid / out_ready
//                     out_last
// cfg      input      cfg_index, cfg_wdata                 cfg_we, no wait
//
// A byte is written at once, or a marker is written first and the byte in ST_PUSH (one queue write port).
// A tick that strobes two power-up nibbles goes on to ST_SECOND; a queued entry is first
// read into a register, then sent from ST_READ, and a queued byte's low nibble from ST_SECOND.
// A second nibble strobe is registered and leaves in the cycle after the first is taken.
// Reset is synchronous; the queue has no clearing pass, reads follow the fill count.
// A new transaction is taken in ST_IDLE once the output register is free or being emptied.
`timescale 1ns / 1ps

module char_lcd_nibble_interface_queue #(
  parameter int QUEUE_DEPTH = clniq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [clniq_pkg::CMD_W-1:0]    in_cmd,
  input  logic [clniq_pkg::DATA_W-1:0]   in_data_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [clniq_pkg::KIND_W-1:0]   out_kind,
  output logic                           out_rs_level,
  output logic [clniq_pkg::NIB_W-1:0]    out_nibble,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [clniq_pkg::DATA_W-1:0]   cfg_wdata
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FILL_LIMIT = CW'(QUEUE_DEPTH - 3);

  clniq_pkg::state_t state_r, state_nxt;

  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          cmd_kind_r, cmd_kind_nxt;
  logic          rs_r, rs_nxt;
  logic [clniq_pkg::START_W-1:0] startup_r, startup_nxt;
  logic [clniq_pkg::PACE_W-1:0]  pace_r, pace_nxt, pace_inc;
  logic [clniq_pkg::DATA_W-1:0]  init_fn_r, disp_ctl_r;
  logic [clniq_pkg::DATA_W-1:0]  hold_byte_r, hold_byte_nxt;
  logic [clniq_pkg::NIB_W-1:0]   sec_nib_r, sec_nib_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [clniq_pkg::KIND_W-1:0]  out_kind_r, out_kind_nxt;
  logic                          out_rs_r, out_rs_nxt;
  logic [clniq_pkg::NIB_W-1:0]   out_nib_r, out_nib_nxt;
  logic                          out_last_r, out_last_nxt;

  logic [clniq_pkg::ENTRY_W-1:0] mem [QUEUE_DEPTH];
  logic [clniq_pkg::ENTRY_W-1:0] rdata_r, mem_wd;
  logic [AW-1:0]                 mem_wa;
  logic                          mem_we, mem_re;

  logic accept, slot_free, is_tick, is_queue, want_char, q_full, need_marker, do_read;
  logic st_emit, st_two;
  logic [clniq_pkg::NIB_W-1:0] st_hi, st_lo;

  assign slot_free   = !out_valid_r || out_ready;
  assign in_ready    = (state_r == clniq_pkg::ST_IDLE) && slot_free;
  assign accept      = in_valid && in_ready;
  assign is_tick     = (in_cmd == clniq_pkg::CMD_TICK);
  assign is_queue    = (in_cmd == clniq_pkg::CMD_COMMAND) || (in_cmd == clniq_pkg::CMD_CHAR);
  assign want_char   = (in_cmd == clniq_pkg::CMD_CHAR);
  assign q_full      = (fill_r > FILL_LIMIT);
  assign need_marker = (cmd_kind_r == want_char);
  assign pace_inc    = (pace_r < clniq_pkg::PACE_TOP) ? pace_r + 1'b1 : pace_r;
  assign do_read     = (startup_r == '0) && (fill_r != '0) && (pace_inc == clniq_pkg::PACE_TOP);

  // power-up step decode
  always_comb begin
    st_emit = 1'b0;
    st_two  = 1'b0;
    st_hi   = clniq_pkg::EARLY_NIBBLE;
    st_lo   = '0;
    case (startup_r)
      clniq_pkg::STEP_WAKE, clniq_pkg::STEP_PULSE_A, clniq_pkg::STEP_PULSE_B: begin
        st_emit = 1'b1;
      end
      clniq_pkg::STEP_FUNC_HI: begin
        st_emit = 1'b1;
        st_hi   = init_fn_r[7:4];
      end
      clniq_pkg::STEP_FUNC: begin
        st_emit = 1'b1;
        st_two  = 1'b1;
        st_hi   = init_fn_r[7:4];
        st_lo   = init_fn_r[3:0];
      end
      clniq_pkg::STEP_DISPLAY: begin
        st_emit = 1'b1;
        st_two  = 1'b1;
        st_hi   = disp_ctl_r[7:4];
        st_lo   = disp_ctl_r[3:0];
      end
      default: begin
        st_emit = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      clniq_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_queue && !q_full && need_marker) begin
            state_nxt = clniq_pkg::ST_PUSH;
          end else if (is_tick && startup_r != '0 && st_two) begin
            state_nxt = clniq_pkg::ST_SECOND;
          end else if (is_tick && do_read) begin
            state_nxt = clniq_pkg::ST_READ;
          end
        end
      end
      clniq_pkg::ST_PUSH: begin
        state_nxt = clniq_pkg::ST_IDLE;
      end
      clniq_pkg::ST_READ: begin
        state_nxt = rdata_r[clniq_pkg::ENTRY_W-1] ? clniq_pkg::ST_IDLE : clniq_pkg::ST_SECOND;
      end
      clniq_pkg::ST_SECOND: begin
        if (out_ready) begin
          state_nxt = clniq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = clniq_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    fill_nxt      = fill_r;
    cmd_kind_nxt  = cmd_kind_r;
    rs_nxt        = rs_r;
    startup_nxt   = startup_r;
    pace_nxt      = pace_r;
    hold_byte_nxt = hold_byte_r;
    sec_nib_nxt   = sec_nib_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_rs_nxt    = out_rs_r;
    out_nib_nxt   = out_nib_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_wa        = wp_r;
    mem_wd        = {1'b0, in_data_byte};
    mem_re        = 1'b0;
    case (state_r)
      clniq_pkg::ST_IDLE: begin
        if (accept && is_queue) begin
          out_valid_nxt = 1'b1;
          out_rs_nxt    = rs_r;
          out_nib_nxt   = '0;
          out_last_nxt  = 1'b1;
          if (q_full) begin
            out_kind_nxt = clniq_pkg::KIND_DROPPED;
          end else begin
            out_kind_nxt = clniq_pkg::KIND_QUEUED;
            mem_we       = 1'b1;
            wp_nxt       = (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
            fill_nxt     = fill_r + 1'b1;
            if (need_marker) begin
              mem_wd        = {1'b1, 7'd0, want_char};
              cmd_kind_nxt  = !want_char;
              hold_byte_nxt = in_data_byte;
            end
          end
        end else if (accept && is_tick) begin
          pace_nxt = pace_inc;
          if (startup_r != '0) begin
            rs_nxt      = 1'b0;
            startup_nxt = startup_r - 1'b1;
            if (st_emit) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = clniq_pkg::KIND_STROBE;
              out_rs_nxt    = 1'b0;
              out_nib_nxt   = st_hi;
              out_last_nxt  = !st_two;
              sec_nib_nxt   = st_lo;
            end
          end else if (do_read) begin
            mem_re = 1'b1;
          end
        end
      end
      clniq_pkg::ST_PUSH: begin
        mem_we   = 1'b1;
        mem_wd   = {1'b0, hold_byte_r};
        wp_nxt   = (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
        fill_nxt = fill_r + 1'b1;
      end
      clniq_pkg::ST_READ: begin
        rp_nxt        = (rp_r == PTR_LAST) ? '0 : rp_r + 1'b1;
        fill_nxt      = fill_r - 1'b1;
        out_valid_nxt = 1'b1;
        if (rdata_r[clniq_pkg::ENTRY_W-1]) begin
          rs_nxt       = rdata_r[0];
          out_kind_nxt = clniq_pkg::KIND_RS;
          out_rs_nxt   = rdata_r[0];
          out_nib_nxt  = '0;
          out_last_nxt = 1'b1;
        end else begin
          if (rdata_r[7:0] < clniq_pkg::SLOW_LIMIT) begin
            pace_nxt = clniq_pkg::SLOW_RELOAD;
          end
          out_kind_nxt = clniq_pkg::KIND_STROBE;
          out_rs_nxt   = rs_r;
          out_nib_nxt  = rdata_r[7:4];
          out_last_nxt = 1'b0;
          sec_nib_nxt  = rdata_r[3:0];
        end
      end
      clniq_pkg::ST_SECOND: begin
        if (out_ready) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = clniq_pkg::KIND_STROBE;
          out_rs_nxt    = rs_r;
          out_nib_nxt   = sec_nib_r;
          out_last_nxt  = 1'b1;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // queue memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= mem[rp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= clniq_pkg::ST_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      fill_r      <= '0;
      cmd_kind_r  <= 1'b1;
      rs_r        <= 1'b0;
      startup_r   <= clniq_pkg::STARTUP_TICKS;
      pace_r      <= '0;
      out_valid_r <= 1'b0;
      init_fn_r   <= clniq_pkg::INIT_FUNCTION_RST;
      disp_ctl_r  <= clniq_pkg::DISPLAY_CONTROL_RST;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      fill_r      <= fill_nxt;
      cmd_kind_r  <= cmd_kind_nxt;
      rs_r        <= rs_nxt;
      startup_r   <= startup_nxt;
      pace_r      <= pace_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == clniq_pkg::REG_INIT_FUNCTION) begin
        init_fn_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == clniq_pkg::REG_DISPLAY_CONTROL) begin
        disp_ctl_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    hold_byte_r <= hold_byte_nxt;
    sec_nib_r   <= sec_nib_nxt;
    out_kind_r  <= out_kind_nxt;
    out_rs_r    <= out_rs_nxt;
    out_nib_r   <= out_nib_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_rs_level = out_rs_r;
  assign out_nibble   = out_nib_r;
  assign out_last     = out_last_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  a_read_issued: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == clniq_pkg::ST_READ) |-> $past(mem_re))
    else $error("read state entered without a memory read");

  a_second_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == clniq_pkg::ST_SECOND |-> out_valid_r)
    else $error("second strobe pending with empty output register");

  a_startup_rs: assert property (@(posedge clk) disable iff (!rst_n)
    startup_r != '0 |-> rs_r == 1'b0)
    else $error("register select changed during power-up");

endmodule
